// ===== rtl/pixel_run_delta_encoder_macros.svh =====
// Assertion macros shared by the pixel run / delta encoder RTL.
`ifndef PIXEL_RUN_DELTA_ENCODER_MACROS_SVH
`define PIXEL_RUN_DELTA_ENCODER_MACROS_SVH

// Condition must never hold while out of reset.
`define PRDE_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define PRDE_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define PRDE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/prde_pkg.sv =====
// Shared types and constants of the pixel run / delta encoder.
package prde_pkg;

    // Run length width and cap
    localparam int RUN_BITS = 20;
    localparam logic [RUN_BITS-1:0] RUN_CAP = '1;

    // Symbol codes
    localparam logic [31:0] CODE_ZERO_DELTA_RUN = 32'h0010_0000;
    localparam logic [31:0] CODE_COLOR_RUN      = 32'h0030_0000;
    localparam logic [31:0] CODE_DELTA_RUN      = 32'h0040_0000;

    // Kind of a run flush
    localparam logic [1:0] KIND_LITERAL   = 2'd0;
    localparam logic [1:0] KIND_COLOR_RUN = 2'd1;
    localparam logic [1:0] KIND_ZERO_RUN  = 2'd2;
    localparam logic [1:0] KIND_DELTA_RUN = 2'd3;

    // Queue between front and back
    localparam int QUEUE_DEPTH    = 4;
    localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    // Input beat
    typedef struct packed {
        logic [31:0] pixel_color;
        logic [31:0] reference_color;
        logic        end_of_frame;
    } pixel_t;

    // Output beat
    typedef struct packed {
        logic [31:0] output_word;
        logic        last_word;
    } symbol_t;

    // One run flush: one or two words
    typedef struct packed {
        logic                valid;
        logic [1:0]          kind;
        logic [RUN_BITS-1:0] len;
        logic [31:0]         data;
    } flush_t;

    // Work for the back part caused by one pixel: run break, then end of frame
    typedef struct packed {
        flush_t first;
        flush_t second;
    } job_t;

endpackage

// ===== rtl/prde_front.sv =====
// Front part: delta forming, run tracking and flush classification.
module prde_front
(
    input  logic            clk,
    input  logic            rst_n,
    input  prde_pkg::pixel_t pixel,
    input  logic            accept,
    output prde_pkg::job_t  job,
    output logic            job_has_word
);
    import prde_pkg::*;

    logic [31:0]         held_color_reg, held_color_next;
    logic [31:0]         held_delta_reg, held_delta_next;
    logic [RUN_BITS-1:0] color_len_reg, color_len_next;
    logic [RUN_BITS-1:0] delta_len_reg, delta_len_next;

    logic [31:0]         delta;
    logic                color_same;
    logic                delta_same;
    logic                run_break;
    logic [RUN_BITS-1:0] color_len_upd;
    logic [RUN_BITS-1:0] delta_len_upd;
    flush_t              break_flush;
    flush_t              frame_flush;

    // Classify a held run into the symbol that flushes it
    function automatic flush_t classify(
        input logic [RUN_BITS-1:0] cr,
        input logic [RUN_BITS-1:0] dr,
        input logic [31:0]         hc,
        input logic [31:0]         hd
    );
        flush_t f;
        f.valid = (cr != '0) || (dr != '0);
        if (cr >= dr) begin
            f.len  = cr;
            f.data = hc;
            f.kind = (cr == RUN_BITS'(1)) ? KIND_LITERAL : KIND_COLOR_RUN;
        end
        else begin
            f.len  = dr;
            f.data = hd;
            f.kind = (hd == '0) ? KIND_ZERO_RUN : KIND_DELTA_RUN;
        end
        return f;
    endfunction

    // Form the delta: zero on match, pixel on empty reference, else per byte
    always_comb
    begin
        if (pixel.pixel_color == pixel.reference_color) begin
            delta = '0;
        end
        else if (pixel.reference_color == '0) begin
            delta = pixel.pixel_color;
        end
        else begin
            for (int b = 0; b < 4; b++) begin
                delta[8*b +: 8] = pixel.pixel_color[8*b +: 8] - pixel.reference_color[8*b +: 8];
            end
        end
    end

    // Decide whether the held run breaks and advance both runs
    always_comb
    begin
        color_same = (held_color_reg == pixel.pixel_color);
        delta_same = (held_delta_reg == delta);
        run_break  = (!color_same && (color_len_reg > delta_len_reg)) ||
                     (!delta_same && (delta_len_reg > color_len_reg)) ||
                     (!delta_same && !color_same) ||
                     (delta_len_reg == RUN_CAP) || (color_len_reg == RUN_CAP);

        if (run_break) begin
            color_len_upd = RUN_BITS'(1);
            delta_len_upd = RUN_BITS'(1);
        end
        else begin
            color_len_upd = color_same ? color_len_reg + RUN_BITS'(1) : RUN_BITS'(1);
            delta_len_upd = delta_same ? delta_len_reg + RUN_BITS'(1) : RUN_BITS'(1);
        end

        break_flush = classify(color_len_reg, delta_len_reg, held_color_reg, held_delta_reg);
        frame_flush = classify(color_len_upd, delta_len_upd, pixel.pixel_color, delta);

        job.first        = break_flush;
        job.first.valid  = run_break && break_flush.valid;
        job.second       = frame_flush;
        job.second.valid = pixel.end_of_frame && frame_flush.valid;
        job_has_word     = job.first.valid || job.second.valid;

        // End of frame returns to the reset state
        if (pixel.end_of_frame) begin
            held_color_next = '0;
            held_delta_next = '0;
            color_len_next  = '0;
            delta_len_next  = '0;
        end
        else begin
            held_color_next = pixel.pixel_color;
            held_delta_next = delta;
            color_len_next  = color_len_upd;
            delta_len_next  = delta_len_upd;
        end
    end

    // Hold run state; advance on an accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_color_reg <= '0;
            held_delta_reg <= '0;
            color_len_reg  <= '0;
            delta_len_reg  <= '0;
        end
        else if (accept) begin
            held_color_reg <= held_color_next;
            held_delta_reg <= held_delta_next;
            color_len_reg  <= color_len_next;
            delta_len_reg  <= delta_len_next;
        end
    end

endmodule

// ===== rtl/prde_queue.sv =====
// Short queue of flush jobs between the front and back parts.
`include "pixel_run_delta_encoder_macros.svh"

module prde_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           wr_en,
    input  prde_pkg::job_t wr_job,
    output logic           full,
    input  logic           rd_en,
    output prde_pkg::job_t head,
    output logic           empty
);
    import prde_pkg::*;

    job_t                      entries_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_BITS-1:0] count_reg, count_next;
    logic                      wr_ok;
    logic                      rd_ok;

    assign full  = (count_reg == QUEUE_CNT_BITS'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entries_reg[rd_ptr_reg];
    assign wr_ok = wr_en && !full;
    assign rd_ok = rd_en && !empty;

    // Advance pointers with wrap at the depth
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_ok) begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        if (rd_ok) begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_BITS'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + QUEUE_PTR_BITS'(1);
        end
        if (wr_ok && !rd_ok) begin
            count_next = count_reg + QUEUE_CNT_BITS'(1);
        end
        else if (rd_ok && !wr_ok) begin
            count_next = count_reg - QUEUE_CNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the written job
    always_ff @(posedge clk)
    begin
        if (wr_ok) begin
            entries_reg[wr_ptr_reg] <= wr_job;
        end
    end

    `PRDE_ASSERT_NEVER(a_count_bound, clk, rst_n, count_reg > QUEUE_CNT_BITS'(QUEUE_DEPTH), "queue count beyond depth")
    `PRDE_ASSERT_IMPLIES(a_job_has_word, clk, rst_n, !empty, head.first.valid || head.second.valid, "queued job without words")
    `PRDE_ASSERT_NEXT(a_head_holds, clk, rst_n, !empty && !rd_en, head == $past(head), "queue head changed without a read")

endmodule

// ===== rtl/prde_back.sv =====
// Back part: expands flush jobs into symbol words behind an output register.
`include "pixel_run_delta_encoder_macros.svh"

module prde_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  prde_pkg::job_t   head,
    input  logic             head_valid,
    output logic             head_done,
    output prde_pkg::symbol_t symbol,
    output logic             empty,
    input  logic             pop
);
    import prde_pkg::*;

    logic [1:0]  idx_reg, idx_next;
    logic [2:0]  idx_ext;
    logic        out_valid_reg, out_valid_next;
    symbol_t     out_reg, out_next;

    logic [1:0]  first_words;
    logic [1:0]  second_words;
    logic [2:0]  total_words;
    logic [2:0]  second_idx;
    logic [31:0] word;
    logic        word_last;
    logic        advance;

    // Words taken by one flush
    function automatic logic [1:0] word_count(input flush_t f);
        logic [1:0] n;
        if (!f.valid) begin
            n = 2'd0;
        end
        else if (f.kind == KIND_LITERAL || f.kind == KIND_ZERO_RUN) begin
            n = 2'd1;
        end
        else begin
            n = 2'd2;
        end
        return n;
    endfunction

    // Word of a flush: header code and length first, then color or delta
    function automatic logic [31:0] flush_word(input flush_t f, input logic sel);
        logic [31:0] code;
        logic [31:0] w;
        unique case (f.kind)
            KIND_COLOR_RUN: code = CODE_COLOR_RUN;
            KIND_ZERO_RUN:  code = CODE_ZERO_DELTA_RUN;
            KIND_DELTA_RUN: code = CODE_DELTA_RUN;
            default:        code = '0;
        endcase
        if (sel || f.kind == KIND_LITERAL) begin
            w = f.data;
        end
        else begin
            w = code | 32'(f.len);
        end
        return w;
    endfunction

    // Pick the current word of the head job
    always_comb
    begin
        first_words  = word_count(head.first);
        second_words = word_count(head.second);
        total_words  = {1'b0, first_words} + {1'b0, second_words};
        idx_ext      = {1'b0, idx_reg};
        second_idx   = idx_ext - {1'b0, first_words};
        if (idx_ext < {1'b0, first_words}) begin
            word = flush_word(head.first, idx_reg[0]);
        end
        else begin
            word = flush_word(head.second, second_idx[0]);
        end
        word_last = (idx_ext + 3'd1 == total_words);
    end

    // Load the output register when it is free or being taken
    always_comb
    begin
        advance        = head_valid && (!out_valid_reg || pop);
        head_done      = advance && word_last;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        if (advance) begin
            out_valid_next       = 1'b1;
            out_next.output_word = word;
            out_next.last_word   = word_last;
            idx_next             = word_last ? 2'd0 : idx_reg + 2'd1;
        end
        else if (pop) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else begin
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Hold the output beat
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign symbol = out_reg;
    assign empty  = !out_valid_reg;

    `PRDE_ASSERT_NEVER(a_idx_in_range, clk, rst_n, head_valid && (idx_ext >= total_words), "word index beyond job")

endmodule

// ===== rtl/pixel_run_delta_encoder.sv =====
// Top level of the pixel run / delta encoder.
//
// Takes one pixel beat per cycle (push/full) and delivers 32-bit symbol
// words through a queue-style output (empty/pop), one word per cycle. The
// front part forms the delta and tracks the color and delta runs; each pixel
// that ends a run or a frame queues one job of up to four words in a
// four-entry job queue. The back part drains that queue into an output
// register at one word per cycle while it is free or popped, so a pixel
// stream that averages at most one word per pixel runs at one pixel per
// cycle; full rises only when four jobs wait. Words reach symbol via the job
// queue and the output register. last_word marks the final word of a pixel.
module pixel_run_delta_encoder
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    output logic              full,
    input  prde_pkg::pixel_t  pixel,
    output logic              empty,
    input  logic              pop,
    output prde_pkg::symbol_t symbol
);
    import prde_pkg::*;

    logic accept;
    job_t job;
    logic job_has_word;
    job_t head;
    logic queue_empty;
    logic head_done;

    assign accept = push && !full;

    prde_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel        (pixel),
        .accept       (accept),
        .job          (job),
        .job_has_word (job_has_word)
    );

    prde_queue u_queue
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (accept && job_has_word),
        .wr_job (job),
        .full   (full),
        .rd_en  (head_done),
        .head   (head),
        .empty  (queue_empty)
    );

    prde_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .head_valid (!queue_empty),
        .head_done  (head_done),
        .symbol     (symbol),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

// ===== test/pixel_run_delta_encoder_tb.sv =====
// Self-checking testbench for the pixel run / delta encoder.
`timescale 1ns / 1ps

module pixel_run_delta_encoder_tb;

    import prde_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 20;
    localparam int PHASE_ITEMS    = 85;

    // Kinds of random pixel sequences
    typedef enum int {
        SEQ_COLOR,
        SEQ_ZERO_DELTA,
        SEQ_DELTA,
        SEQ_NO_REF,
        SEQ_NOISE,
        SEQ_SWITCH
    } seq_kind_e;

    // One queued pixel with the idling that goes with it
    typedef struct packed {
        pixel_t     px;
        logic [6:0] idle_pct;
        logic [6:0] stall_pct;
    } queued_pixel_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    push = 1'b0;
    logic    full;
    pixel_t  pixel = '0;
    logic    empty;
    logic    pop = 1'b0;
    symbol_t symbol;

    queued_pixel_t pixel_queue[$];
    symbol_t       expected_symbols[$];
    int            symbol_errors = 0;
    int            idle_cycles = 0;
    logic [6:0]    recv_stall_pct = '0;
    logic [6:0]    cur_idle = '0;
    logic [6:0]    cur_stall = '0;

    // Run tracker state
    logic [31:0]         run_color = '0;
    logic [31:0]         run_delta = '0;
    logic [RUN_BITS-1:0] color_len = '0;
    logic [RUN_BITS-1:0] delta_len = '0;
    logic [31:0]         step_words[4];
    int                  step_count;

    logic [31:0] palette[4] = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF, 32'h8080_8080};

    pixel_run_delta_encoder u_top
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .pixel  (pixel),
        .empty  (empty),
        .pop    (pop),
        .symbol (symbol)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Add the bytes of a delta to a reference, each byte wrapping
    function automatic logic [31:0] add_bytes(input logic [31:0] base, input logic [31:0] d);
        logic [31:0] sum;
        for (int i = 0; i < 4; i++)
        begin
            sum[8*i +: 8] = base[8*i +: 8] + d[8*i +: 8];
        end
        return sum;
    endfunction

    task automatic add_item(input logic [31:0] color, input logic [31:0] refc, input logic eof);
        queued_pixel_t q;
        q.px.pixel_color     = color;
        q.px.reference_color = refc;
        q.px.end_of_frame    = eof;
        q.idle_pct           = cur_idle;
        q.stall_pct          = cur_stall;
        pixel_queue.push_back(q);
    endtask

    task automatic add_word(input logic [31:0] w);
        step_words[step_count] = w;
        step_count++;
    endtask

    // Emit the longer of the held runs; color wins a tie
    task automatic emit_held_run();
        if (color_len != 0 || delta_len != 0)
        begin
            if (color_len >= delta_len)
            begin
                if (color_len == 1)
                begin
                    add_word(run_color);
                end
                else
                begin
                    add_word(CODE_COLOR_RUN | {12'd0, color_len});
                    add_word(run_color);
                end
            end
            else if (run_delta == 0)
            begin
                add_word(CODE_ZERO_DELTA_RUN | {12'd0, delta_len});
            end
            else
            begin
                add_word(CODE_DELTA_RUN | {12'd0, delta_len});
                add_word(run_delta);
            end
        end
    endtask

    // Advance the run tracker by one pixel and queue the words it causes
    task automatic predict_symbols(input pixel_t px);
        logic [31:0] d;
        logic        color_hit;
        logic        delta_hit;
        symbol_t     s;
        step_count = 0;
        if (px.pixel_color == px.reference_color)
        begin
            d = '0;
        end
        else if (px.reference_color == 0)
        begin
            d = px.pixel_color;
        end
        else
        begin
            for (int i = 0; i < 4; i++)
            begin
                d[8*i +: 8] = px.pixel_color[8*i +: 8] - px.reference_color[8*i +: 8];
            end
        end
        color_hit = (run_color == px.pixel_color);
        delta_hit = (run_delta == d);
        if ((!color_hit && color_len > delta_len) || (!delta_hit && delta_len > color_len) ||
            (!color_hit && !delta_hit) || color_len == RUN_CAP || delta_len == RUN_CAP)
        begin
            emit_held_run();
            run_color = px.pixel_color;
            run_delta = d;
            color_len = 1;
            delta_len = 1;
        end
        else
        begin
            if (color_hit)
            begin
                color_len = color_len + 1'b1;
            end
            else
            begin
                run_color = px.pixel_color;
                color_len = 1;
            end
            if (delta_hit)
            begin
                delta_len = delta_len + 1'b1;
            end
            else
            begin
                run_delta = d;
                delta_len = 1;
            end
        end
        // Flush at end of frame and drop back to the reset state
        if (px.end_of_frame)
        begin
            emit_held_run();
            run_color = '0;
            run_delta = '0;
            color_len = '0;
            delta_len = '0;
        end
        for (int i = 0; i < step_count; i++)
        begin
            s.output_word = step_words[i];
            s.last_word   = (i == step_count - 1);
            expected_symbols.push_back(s);
        end
    endtask

    // Driver: predict on each accepted beat, then offer the next pixel or idle
    always @(posedge clk)
    begin : drive_blk
        queued_pixel_t head;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            if (push && !full)
            begin
                predict_symbols(pixel);
            end
            if (!push || !full)
            begin
                if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= pixel_queue[0].idle_pct)
                begin
                    head = pixel_queue.pop_front();
                    pixel <= head.px;
                    push <= 1'b1;
                    recv_stall_pct <= head.stall_pct;
                end
                else
                begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted symbol beat against the oldest expectation
    always @(posedge clk)
    begin : monitor_blk
        symbol_t want;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                if (expected_symbols.size() == 0)
                begin
                    $error("unexpected symbol beat: output_word %h last_word %b",
                           symbol.output_word, symbol.last_word);
                    symbol_errors++;
                end
                else
                begin
                    want = expected_symbols.pop_front();
                    if (symbol.output_word !== want.output_word)
                    begin
                        $error("output_word: expected %h, actual %h",
                               want.output_word, symbol.output_word);
                        symbol_errors++;
                    end
                    if (symbol.last_word !== want.last_word)
                    begin
                        $error("last_word: expected %b, actual %b",
                               want.last_word, symbol.last_word);
                        symbol_errors++;
                    end
                end
            end
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: end the run when no beat moves for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((push && !full) || (pop && !empty))
            begin
                idle_cycles <= 0;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    initial
    begin : stimulus_blk
        logic [31:0] c;
        logic [31:0] r;
        logic [31:0] d;
        logic [31:0] color;
        logic [31:0] refc;
        logic        eof;
        seq_kind_e   kind;
        int          len;
        int          added;

        // Directed: zero pixel after reset, then flush the two-pixel run
        add_item(32'h0000_0000, 32'h0000_0000, 1'b0);
        add_item(32'h0000_0000, 32'h0000_0000, 1'b1);
        // Single pixels flushed as literals, one with no reference
        add_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        add_item(32'h1234_5678, 32'h0000_0000, 1'b1);
        // Zero-delta run
        add_item(32'hA1B2_C3D4, 32'hA1B2_C3D4, 1'b0);
        add_item(32'h0F1E_2D3C, 32'h0F1E_2D3C, 1'b0);
        add_item(32'hDEAD_BEEF, 32'hDEAD_BEEF, 1'b1);
        // Nonzero delta run with byte wrap
        add_item(add_bytes(32'h10FF_2080, 32'h01FF_80FE), 32'h10FF_2080, 1'b0);
        add_item(add_bytes(32'hFF01_7F02, 32'h01FF_80FE), 32'hFF01_7F02, 1'b0);
        add_item(add_bytes(32'h0203_0405, 32'h01FF_80FE), 32'h0203_0405, 1'b1);
        // Color run broken by a new pixel on an end of frame
        add_item(32'h00C0_FFEE, 32'h1111_1111, 1'b0);
        add_item(32'h00C0_FFEE, 32'h2222_2222, 1'b0);
        add_item(32'h00C0_FFEE, 32'h3333_3333, 1'b0);
        add_item(32'h7654_3210, 32'h4444_4444, 1'b1);
        // Tie between color and delta runs
        add_item(32'h5555_AAAA, 32'h0000_0000, 1'b0);
        add_item(32'h5555_AAAA, 32'h0000_0000, 1'b1);
        // Byte extremes
        add_item(32'hFFFF_FFFF, 32'h0000_0001, 1'b0);
        add_item(32'h0000_0000, 32'hFFFF_FFFF, 1'b1);
        add_item(32'h8080_8080, 32'h7F7F_7F7F, 1'b0);
        add_item(32'h7F7F_7F7F, 32'h8080_8080, 1'b1);

        // Random phases with different idling on each side
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0: begin cur_idle = 7'd0;  cur_stall = 7'd0;  end
                1: begin cur_idle = 7'd71; cur_stall = 7'd0;  end
                2: begin cur_idle = 7'd0;  cur_stall = 7'd71; end
                default: begin cur_idle = 7'd25; cur_stall = 7'd25; end
            endcase
            added = 0;
            while (added < PHASE_ITEMS)
            begin
                len  = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 6);
                kind = seq_kind_e'($urandom_range(0, 5));
                c    = ($urandom_range(0, 3) == 0) ? palette[$urandom_range(0, 3)] : $urandom();
                r    = ($urandom_range(0, 3) == 0) ? 32'h0 : $urandom();
                d    = ($urandom_range(0, 7) == 0) ? palette[$urandom_range(0, 3)] : $urandom();
                for (int j = 0; j < len; j++)
                begin
                    case (kind)
                        SEQ_COLOR:
                        begin
                            color = c;
                            refc  = ($urandom_range(0, 3) == 0) ? $urandom() : r;
                        end
                        SEQ_ZERO_DELTA:
                        begin
                            color = $urandom();
                            refc  = color;
                        end
                        SEQ_DELTA:
                        begin
                            refc  = $urandom();
                            color = add_bytes(refc, d);
                        end
                        SEQ_NO_REF:
                        begin
                            color = c;
                            refc  = 32'h0;
                        end
                        SEQ_SWITCH:
                        begin
                            refc  = $urandom();
                            color = (j < len / 2) ? c : add_bytes(refc, d);
                        end
                        default:
                        begin
                            color = $urandom();
                            case ($urandom_range(0, 2))
                                0: refc = 32'h0;
                                1: refc = color;
                                default: refc = $urandom();
                            endcase
                        end
                    endcase
                    eof = ((j == len - 1) && $urandom_range(0, 4) == 0) ||
                          ($urandom_range(0, 49) == 0);
                    add_item(color, refc, eof);
                end
                added += len;
            end
        end

        // Release reset, then wait for every pixel and symbol to move
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        while (pixel_queue.size() != 0 || push || expected_symbols.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (symbol_errors == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
